[rtl/lppd_pkg.sv]
package lppd_pkg;

    // payload buffer depth, the kept-count and index widths that go with it, and the length and class widths
    localparam int unsigned BUFFER_SIZE = 1024;
    localparam int unsigned KEPT_W      = $clog2(BUFFER_SIZE + 1);
    localparam int unsigned INDEX_W     = 10;
    localparam int unsigned LEN_W       = 24;
    localparam int unsigned CLASS_W     = 2;

    // byte classification codes
    localparam logic [CLASS_W-1:0] CLS_HEADER = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_KEPT   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_SKIP   = 2'd2;

    // header byte positions
    localparam logic [1:0] HDR_LEN0 = 2'd0;
    localparam logic [1:0] HDR_LEN1 = 2'd1;
    localparam logic [1:0] HDR_LEN2 = 2'd2;
    localparam logic [1:0] HDR_SEQ  = 2'd3;

endpackage

[rtl/length_prefixed_packet_deframer_top.sv]
// Length-prefixed packet deframer. Each input transaction carries one byte of a packet
// stream and produces exactly one result transaction: the byte, its class (header, kept
// payload, skipped payload), the buffer index of a kept byte and, on the byte that
// completes the kept part of a packet (or the last header byte of an empty packet), the
// sequence number, declared length and kept length. A packet is a 3-byte little-endian
// length, a sequence byte, then the payload; at most BUFFER_SIZE payload bytes are kept.
// One byte is accepted every cycle unless stalled: the per-byte counters update in the
// accepting cycle and the result sits in a single output register, so it appears in the next
// cycle; the input is stalled only while that register is full and stalled downstream.
module length_prefixed_packet_deframer_top
    import lppd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CLASS_W-1:0] o_byte_class,
    output logic [7:0]         o_data_out,
    output logic [INDEX_W-1:0] o_payload_index,
    output logic               o_packet_done,
    output logic [7:0]         o_seq_number,
    output logic [LEN_W-1:0]   o_declared_length,
    output logic [KEPT_W-1:0]  o_kept_length
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_KEEP   = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_hdr_count, n_hdr_count;
    logic [LEN_W-1:0]    r_length, n_length;
    logic [7:0]          r_seq, n_seq;
    logic [KEPT_W-1:0]   r_kept_count, n_kept_count;
    logic [LEN_W-1:0]    r_skip_count, n_skip_count;

    logic                r_out_valid;
    logic [CLASS_W-1:0]  r_class, n_class;
    logic [7:0]          r_data;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic                r_done, n_done;
    logic [7:0]          r_seq_out;
    logic [LEN_W-1:0]    r_len_out;
    logic [KEPT_W-1:0]   r_kept_out;

    logic                w_accept;
    logic [KEPT_W-1:0]   w_kept_inc;

    // output register frees when taken downstream
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_kept_inc = r_kept_count + KEPT_W'(1);

    // per-byte framing decision
    always_comb begin
        n_phase      = r_phase;
        n_hdr_count  = r_hdr_count;
        n_length     = r_length;
        n_seq        = r_seq;
        n_kept_count = r_kept_count;
        n_skip_count = r_skip_count;
        n_class      = CLS_HEADER;
        n_index      = '0;
        n_done       = 1'b0;
        case (r_phase)
            PH_KEEP: begin
                n_class      = CLS_KEPT;
                n_index      = r_kept_count[INDEX_W-1:0];
                n_kept_count = w_kept_inc;
                if (LEN_W'(w_kept_inc) == r_length || w_kept_inc == KEPT_W'(BUFFER_SIZE)) begin
                    n_done       = 1'b1;
                    n_skip_count = r_length - LEN_W'(w_kept_inc);
                    n_phase      = (n_skip_count != '0) ? PH_SKIP : PH_HEADER;
                    n_hdr_count  = HDR_LEN0;
                end
            end
            PH_SKIP: begin
                n_class      = CLS_SKIP;
                n_skip_count = r_skip_count - LEN_W'(1);
                if (n_skip_count == '0) begin
                    n_phase     = PH_HEADER;
                    n_hdr_count = HDR_LEN0;
                end
            end
            default: begin
                // header phase, also the unused phase code
                n_class = CLS_HEADER;
                case (r_hdr_count)
                    HDR_LEN0: begin
                        n_length    = {16'd0, i_data_byte};
                        n_hdr_count = HDR_LEN1;
                    end
                    HDR_LEN1: begin
                        n_length    = {8'd0, i_data_byte, r_length[7:0]};
                        n_hdr_count = HDR_LEN2;
                    end
                    HDR_LEN2: begin
                        n_length    = {i_data_byte, r_length[15:0]};
                        n_hdr_count = HDR_SEQ;
                    end
                    default: begin
                        n_seq        = i_data_byte;
                        n_hdr_count  = HDR_LEN0;
                        n_kept_count = '0;
                        n_skip_count = '0;
                        if (r_length == '0) begin
                            n_done  = 1'b1;
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_KEEP;
                        end
                    end
                endcase
            end
        endcase
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_count  <= HDR_LEN0;
            r_length     <= '0;
            r_seq        <= '0;
            r_kept_count <= '0;
            r_skip_count <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_hdr_count  <= n_hdr_count;
            r_length     <= n_length;
            r_seq        <= n_seq;
            r_kept_count <= n_kept_count;
            r_skip_count <= n_skip_count;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_class    <= n_class;
            r_data     <= i_data_byte;
            r_index    <= n_index;
            r_done     <= n_done;
            r_seq_out  <= n_done ? n_seq : 8'd0;
            r_len_out  <= n_done ? n_length : '0;
            r_kept_out <= n_done ? n_kept_count : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_class      = r_class;
    assign o_data_out        = r_data;
    assign o_payload_index   = r_index;
    assign o_packet_done     = r_done;
    assign o_seq_number      = r_seq_out;
    assign o_declared_length = r_len_out;
    assign o_kept_length     = r_kept_out;

    // skip phase always has bytes left to skip
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip_count != '0)
        else $error("skip phase entered with nothing to skip");

    // kept count never passes the buffer size
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= KEPT_W'(BUFFER_SIZE))
        else $error("kept count beyond buffer size");

    // skipped bytes never complete a packet
    a_skip_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_class == CLS_SKIP |-> !o_packet_done)
        else $error("packet done on a skipped byte");

    // done on a header byte only for an empty packet
    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done && o_byte_class == CLS_HEADER
            |-> o_declared_length == '0 && o_kept_length == '0)
        else $error("header done with non-empty payload");

    // entering skip means the kept part filled the buffer
    a_skip_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == PH_KEEP && n_phase == PH_SKIP
            |-> n_kept_count == KEPT_W'(BUFFER_SIZE))
        else $error("skip entered before buffer full");

endmodule
